// ----- hw/rtl/plp_pkg.sv -----
// Shared constants and types for the Phong lighting pipeline.
// Used by the channel interfaces, plp_norm, plp_pow and phong_lighting.
// Depends on nothing.
package plp_pkg;

  // Packed vector and colour words.
  localparam int VEC_W   = 48;
  localparam int LANE_W  = 16;
  localparam int SHINE_W = 8;
  localparam int OUT_W   = 16;

  // Position differences and their magnitudes.
  localparam int DIFF_W  = LANE_W + 1;
  localparam int MAG_W   = DIFF_W;
  localparam int SUMSQ_W = 2 * MAG_W;

  // Square root of the sum of squares scaled by 2^16.
  localparam int SQ_W       = SUMSQ_W + 16;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int LEN_W      = SQRT_STEPS;

  // Unit components in signed Q1.14, magnitude clamped to one.
  localparam int QUO_W     = 15;
  localparam int UNIT_W    = QUO_W + 1;
  localparam int DIV_STEPS = QUO_W - 1;
  localparam int Q14_ONE   = 16384;

  // Pipeline depths.
  localparam int NORM_LAT  = 1 + SQRT_STEPS + 1 + DIV_STEPS;
  localparam int POW_STEPS = SHINE_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_POS  = 3'd0,
    REG_LIGHT_AMB  = 3'd1,
    REG_LIGHT_DIF  = 3'd2,
    REG_LIGHT_SPC  = 3'd3,
    REG_CAMERA_POS = 3'd4
  } cfg_reg_t;

  // Material data that rides alongside the vector math.
  typedef struct packed {
    logic [VEC_W-1:0]   mat_amb;
    logic [VEC_W-1:0]   mat_dif;
    logic [VEC_W-1:0]   mat_spc;
    logic [SHINE_W-1:0] shininess;
  } side_t;

endpackage

// ----- hw/rtl/plp_if.sv -----
// Valid/ready channel interfaces for the Phong lighting pipeline.
// Holds the input, result and configuration channels; depends on plp_pkg.
interface plp_in_if;
  logic                        valid;
  logic                        ready;
  logic [plp_pkg::VEC_W-1:0]   point_position;
  logic [plp_pkg::VEC_W-1:0]   surface_normal;
  logic [plp_pkg::VEC_W-1:0]   material_ambient;
  logic [plp_pkg::VEC_W-1:0]   material_diffuse;
  logic [plp_pkg::VEC_W-1:0]   material_specular;
  logic [plp_pkg::SHINE_W-1:0] shininess;
  modport source (output valid, point_position, surface_normal, material_ambient,
                  material_diffuse, material_specular, shininess, input ready);
  modport sink (input valid, point_position, surface_normal, material_ambient,
                material_diffuse, material_specular, shininess, output ready);
endinterface

interface plp_out_if;
  logic                      valid;
  logic                      ready;
  logic [plp_pkg::OUT_W-1:0] red_out;
  logic [plp_pkg::OUT_W-1:0] green_out;
  logic [plp_pkg::OUT_W-1:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface plp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [plp_pkg::CFG_IDX_W-1:0] index;
  logic [plp_pkg::VEC_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/plp_norm.sv -----
// Pipelined vector normalizer: sum of squares, bit-serial square root and
// clamped restoring division, one stage per result bit. Depends on plp_pkg.
module plp_norm (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [plp_pkg::DIFF_W-1:0]  d_in [3],
  output logic signed [plp_pkg::UNIT_W-1:0]  u_out [3]
);
  import plp_pkg::*;

  localparam int RES_W = SQ_W + 1;
  localparam int REM_W = MAG_W + 22 + 1;

  // Square root stage registers; index 0 is the sum-of-squares stage.
  logic [RES_W-1:0] sq_x_r   [0:SQRT_STEPS-1];
  logic [RES_W-1:0] sq_res_r [0:SQRT_STEPS];
  logic [MAG_W-1:0] sq_mag_r [0:SQRT_STEPS][3];
  logic [2:0]       sq_sgn_r [0:SQRT_STEPS];
  logic             sq_zero_r [0:SQRT_STEPS];

  // Division stage registers; index 0 is the clamp stage.
  logic [REM_W-1:0] dv_rem_r [0:DIV_STEPS-1][3];
  logic [LEN_W-1:0] dv_len_r [0:DIV_STEPS-1];
  logic [QUO_W-1:0] dv_q_r   [0:DIV_STEPS][3];
  logic [2:0]       dv_sgn_r [0:DIV_STEPS];
  logic             dv_zero_r [0:DIV_STEPS];

  // Magnitudes and the sum of their squares.
  logic [MAG_W-1:0]   mag_c [3];
  logic [2:0]         sgn_c;
  logic [SUMSQ_W-1:0] sum_c;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < 3; i++) begin
      sgn_c[i] = d_in[i][DIFF_W-1];
      mag_c[i] = sgn_c[i] ? MAG_W'(-d_in[i]) : MAG_W'(d_in[i]);
      sum_c    = sum_c + SUMSQ_W'(mag_c[i] * mag_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r[0]    <= RES_W'({sum_c, 16'b0});
      sq_res_r[0]  <= '0;
      sq_mag_r[0]  <= mag_c;
      sq_sgn_r[0]  <= sgn_c;
      sq_zero_r[0] <= (sum_c == '0);
    end
  end

  // One result bit of the integer square root per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [RES_W-1:0] bit_c, trial_c, x_nxt, res_nxt;

    always_comb begin
      bit_c   = RES_W'(1) << (SQ_W - 2 - 2 * k);
      trial_c = sq_res_r[k] + bit_c;
      if (sq_x_r[k] >= trial_c) begin
        x_nxt   = sq_x_r[k] - trial_c;
        res_nxt = (sq_res_r[k] >> 1) + bit_c;
      end else begin
        x_nxt   = sq_x_r[k];
        res_nxt = sq_res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_res_r[k+1]  <= res_nxt;
        sq_mag_r[k+1]  <= sq_mag_r[k];
        sq_sgn_r[k+1]  <= sq_sgn_r[k];
        sq_zero_r[k+1] <= sq_zero_r[k];
      end
    end

    if (k < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sq_x_r[k+1] <= x_nxt;
        end
      end
    end
  end

  // Clamp stage: a quotient of one or more becomes exactly one.
  logic [LEN_W-1:0] len_c;
  logic [REM_W-1:0] lim_c;
  logic [REM_W-1:0] dvd_c [3];

  always_comb begin
    len_c = sq_res_r[SQRT_STEPS][LEN_W-1:0];
    lim_c = REM_W'(len_c) << DIV_STEPS;
    for (int i = 0; i < 3; i++) begin
      dvd_c[i] = REM_W'(sq_mag_r[SQRT_STEPS][i]) << 22;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dvd_c[i] >= lim_c) begin
          dv_rem_r[0][i] <= '0;
          dv_q_r[0][i]   <= QUO_W'(Q14_ONE);
        end else begin
          dv_rem_r[0][i] <= dvd_c[i];
          dv_q_r[0][i]   <= '0;
        end
      end
      dv_len_r[0]  <= len_c;
      dv_sgn_r[0]  <= sq_sgn_r[SQRT_STEPS];
      dv_zero_r[0] <= sq_zero_r[SQRT_STEPS];
    end
  end

  // One quotient bit per stage, highest first.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [REM_W-1:0] sh_c;
    logic [REM_W-1:0] rem_nxt [3];
    logic [QUO_W-1:0] q_nxt   [3];

    always_comb begin
      sh_c = REM_W'(dv_len_r[j]) << (DIV_STEPS - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j][i] >= sh_c) begin
          rem_nxt[i] = dv_rem_r[j][i] - sh_c;
          q_nxt[i]   = dv_q_r[j][i] | (QUO_W'(1) << (DIV_STEPS - 1 - j));
        end else begin
          rem_nxt[i] = dv_rem_r[j][i];
          q_nxt[i]   = dv_q_r[j][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q_r[j+1]    <= q_nxt;
        dv_sgn_r[j+1]  <= dv_sgn_r[j];
        dv_zero_r[j+1] <= dv_zero_r[j];
      end
    end

    if (j < DIV_STEPS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[j+1] <= rem_nxt;
          dv_len_r[j+1] <= dv_len_r[j];
        end
      end
    end
  end

  // Restore the sign; a zero-length vector gives the zero vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_r[DIV_STEPS]) begin
        u_out[i] = '0;
      end else if (dv_sgn_r[DIV_STEPS][i]) begin
        u_out[i] = -$signed({1'b0, dv_q_r[DIV_STEPS][i]});
      end else begin
        u_out[i] = $signed({1'b0, dv_q_r[DIV_STEPS][i]});
      end
    end
  end

endmodule

// ----- hw/rtl/plp_pow.sv -----
// Pipelined Q1.14 integer power by square-and-multiply, one exponent bit
// per stage from the lowest. Depends on plp_pkg.
module plp_pow (
  input  logic                          clk,
  input  logic                          en,
  input  logic [plp_pkg::QUO_W-1:0]     base_in,
  input  logic [plp_pkg::SHINE_W-1:0]   exp_in,
  output logic [plp_pkg::QUO_W-1:0]     pow_out
);
  import plp_pkg::*;

  // Rounded Q1.14 product of two values no larger than one.
  function automatic logic [QUO_W-1:0] qmul(input logic [QUO_W-1:0] a,
                                            input logic [QUO_W-1:0] b);
    logic [2*QUO_W:0] p;
    p = (2*QUO_W+1)'(a * b) + (2*QUO_W+1)'(Q14_ONE / 2);
    return QUO_W'(p >> 14);
  endfunction

  logic [QUO_W-1:0]   acc_r [1:POW_STEPS];
  logic [QUO_W-1:0]   sq_r  [1:POW_STEPS-1];
  logic [SHINE_W-1:0] exp_r [1:POW_STEPS-1];

  for (genvar j = 0; j < POW_STEPS; j++) begin : g_step
    logic [QUO_W-1:0]   acc_c, base_c;
    logic [SHINE_W-1:0] exp_c;

    if (j == 0) begin : g_first
      assign acc_c  = QUO_W'(Q14_ONE);
      assign base_c = base_in;
      assign exp_c  = exp_in;
    end else begin : g_next
      assign acc_c  = acc_r[j];
      assign base_c = sq_r[j];
      assign exp_c  = exp_r[j];
    end

    // Multiply in the current base when this exponent bit is set.
    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[j+1] <= exp_c[j] ? qmul(acc_c, base_c) : acc_c;
      end
    end

    if (j < POW_STEPS - 1) begin : g_square
      always_ff @(posedge clk) begin
        if (en) begin
          sq_r[j+1]  <= qmul(base_c, base_c);
          exp_r[j+1] <= exp_c;
        end
      end
    end
  end

  assign pow_out = acc_r[POW_STEPS];

endmodule

// ----- hw/rtl/phong_lighting.sv -----
// Phong lighting pipeline top level: configuration registers, vector
// differences, dot products, factors and colour sum.
// Depends on plp_pkg, plp_if, plp_norm and plp_pow.
//
//  Channel  | Dir | Handshake      | Transaction contents
//  ---------+-----+----------------+----------------------------------------
//  in_ch    | in  | valid / ready  | point, normal, three materials, shininess
//  out_ch   | out | valid / ready  | red, green, blue in Q2.14
//  cfg_ch   | in  | valid / ready  | register index and 48-bit data
//
// One transaction enters per cycle unless the pipeline holds; each passes
// through the 25-stage square root and the divider of the normalizers and
// the 8-stage power unit. Reset clears the valid bits and the configuration
// registers. When the result waits unaccepted, the whole pipeline holds; no
// transaction is lost or repeated. cfg_ch is always ready.
module phong_lighting (
  input  logic      clk,
  input  logic      rst_n,
  plp_in_if.sink    in_ch,
  plp_out_if.source out_ch,
  plp_cfg_if.sink   cfg_ch
);
  import plp_pkg::*;

  localparam int NORM_END   = 1 + NORM_LAT;
  localparam int POW_IN     = NORM_END + 5;
  localparam int SIDE_DEPTH = POW_IN + POW_STEPS;
  localparam int FD_DEPTH   = SIDE_DEPTH - (NORM_END + 3) + 1;
  localparam int LAT        = SIDE_DEPTH + 3;
  localparam int DNL_W      = 34;
  localparam int R_W        = 48;
  localparam int PH_W       = UNIT_W + 24;
  localparam int PL_W       = UNIT_W + 25;
  localparam int DVR_W      = 64;
  localparam int SUM_W      = 48;

  // Configuration registers.
  logic [VEC_W-1:0] light_pos_r, light_amb_r, light_dif_r, light_spc_r, camera_pos_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_pos_r  <= '0;
      light_amb_r  <= '0;
      light_dif_r  <= '0;
      light_spc_r  <= '0;
      camera_pos_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LIGHT_POS:  light_pos_r  <= cfg_ch.data;
        REG_LIGHT_AMB:  light_amb_r  <= cfg_ch.data;
        REG_LIGHT_DIF:  light_dif_r  <= cfg_ch.data;
        REG_LIGHT_SPC:  light_spc_r  <= cfg_ch.data;
        REG_CAMERA_POS: camera_pos_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a result is stuck at the output.
  logic           pipe_en;
  logic [LAT-1:0] vld_r;

  assign pipe_en     = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // Material data travels beside the vector math.
  side_t side_r [0:SIDE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side_r[0] <= '{mat_amb: in_ch.material_ambient, mat_dif: in_ch.material_diffuse,
                     mat_spc: in_ch.material_specular, shininess: in_ch.shininess};
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Light, normal and view vectors before normalization.
  logic signed [DIFF_W-1:0] dl_r [3];
  logic signed [DIFF_W-1:0] dn_r [3];
  logic signed [DIFF_W-1:0] dv_r [3];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        dl_r[i] <= DIFF_W'($signed(light_pos_r[LANE_W*i +: LANE_W]))
                 - DIFF_W'($signed(in_ch.point_position[LANE_W*i +: LANE_W]));
        dv_r[i] <= DIFF_W'($signed(camera_pos_r[LANE_W*i +: LANE_W]))
                 - DIFF_W'($signed(in_ch.point_position[LANE_W*i +: LANE_W]));
        dn_r[i] <= DIFF_W'($signed(in_ch.surface_normal[LANE_W*i +: LANE_W]));
      end
    end
  end

  logic signed [UNIT_W-1:0] l_u [3];
  logic signed [UNIT_W-1:0] n_u [3];
  logic signed [UNIT_W-1:0] v_u [3];

  plp_norm u_norm_l (.clk(clk), .en(pipe_en), .d_in(dl_r), .u_out(l_u));
  plp_norm u_norm_n (.clk(clk), .en(pipe_en), .d_in(dn_r), .u_out(n_u));
  plp_norm u_norm_v (.clk(clk), .en(pipe_en), .d_in(dv_r), .u_out(v_u));

  // N.L products, then their sum.
  logic signed [2*UNIT_W-1:0] nl_r [3];
  logic signed [UNIT_W-1:0]   n1_r [3], l1_r [3], v1_r [3];
  logic signed [DNL_W-1:0]    dnl_r;
  logic signed [UNIT_W-1:0]   n2_r [3], l2_r [3], v2_r [3];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        nl_r[i] <= n_u[i] * l_u[i];
      end
      n1_r  <= n_u;
      l1_r  <= l_u;
      v1_r  <= v_u;
      dnl_r <= DNL_W'(nl_r[0]) + DNL_W'(nl_r[1]) + DNL_W'(nl_r[2]);
      n2_r  <= n1_r;
      l2_r  <= l1_r;
      v2_r  <= v1_r;
    end
  end

  // Reflection vector and diffuse factor.
  logic signed [DNL_W+UNIT_W:0] tn_c [3];
  logic signed [R_W-1:0]        r_nxt [3];
  logic [QUO_W-1:0]             fd_nxt;
  logic [19:0]                  fd_hi_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tn_c[i]  = $signed({dnl_r, 1'b0}) * n2_r[i];
      r_nxt[i] = R_W'(tn_c[i]) - (R_W'(l2_r[i]) <<< 28);
    end
    fd_hi_c = dnl_r[DNL_W-1 -: 20];
    if (dnl_r <= 0) begin
      fd_nxt = '0;
    end else if (fd_hi_c > 20'(Q14_ONE)) begin
      fd_nxt = QUO_W'(Q14_ONE);
    end else begin
      fd_nxt = fd_hi_c[QUO_W-1:0];
    end
  end

  logic signed [R_W-1:0]  r_r [3];
  logic signed [UNIT_W-1:0] v3_r [3];
  logic [QUO_W-1:0]       fd_r [0:FD_DEPTH-1];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      r_r     <= r_nxt;
      v3_r    <= v2_r;
      fd_r[0] <= fd_nxt;
      for (int k = 1; k < FD_DEPTH; k++) begin
        fd_r[k] <= fd_r[k-1];
      end
    end
  end

  // V.R as split partial products, then the wide sum.
  logic signed [PH_W-1:0]  ph_r [3];
  logic signed [PL_W-1:0]  pl_r [3];
  logic signed [DVR_W-1:0] dvr_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        ph_r[i] <= v3_r[i] * $signed(r_r[i][R_W-1:24]);
        pl_r[i] <= v3_r[i] * $signed({1'b0, r_r[i][23:0]});
      end
      dvr_r <= (DVR_W'(ph_r[0]) <<< 24) + DVR_W'(pl_r[0])
             + (DVR_W'(ph_r[1]) <<< 24) + DVR_W'(pl_r[1])
             + (DVR_W'(ph_r[2]) <<< 24) + DVR_W'(pl_r[2]);
    end
  end

  // Specular base, clamped, then raised to the shininess.
  logic [19:0]      fs_hi_c;
  logic [QUO_W-1:0] fs_base_c;
  logic [QUO_W-1:0] fs_pow;

  always_comb begin
    fs_hi_c = dvr_r[61:42];
    if (dvr_r <= 0) begin
      fs_base_c = '0;
    end else if (fs_hi_c > 20'(Q14_ONE)) begin
      fs_base_c = QUO_W'(Q14_ONE);
    end else begin
      fs_base_c = fs_hi_c[QUO_W-1:0];
    end
  end

  plp_pow u_pow (
    .clk    (clk),
    .en     (pipe_en),
    .base_in(fs_base_c),
    .exp_in (side_r[POW_IN-1].shininess),
    .pow_out(fs_pow)
  );

  // Colour: light times material, scaled by the factors, then summed.
  logic [2*LANE_W-1:0] amb_r [3], dif_r [3], spc_r [3];
  logic [QUO_W-1:0]    c_fd_r, c_fs_r;
  logic [SUM_W-1:0]    ta_r [3], td_r [3], ts_r [3];
  logic [OUT_W-1:0]    rgb_r [3];
  logic [SUM_W-1:0]    sum_c [3];
  logic [SUM_W-33:0]   q_c [3];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        amb_r[i] <= light_amb_r[LANE_W*i +: LANE_W]
                  * side_r[SIDE_DEPTH-1].mat_amb[LANE_W*i +: LANE_W];
        dif_r[i] <= light_dif_r[LANE_W*i +: LANE_W]
                  * side_r[SIDE_DEPTH-1].mat_dif[LANE_W*i +: LANE_W];
        spc_r[i] <= light_spc_r[LANE_W*i +: LANE_W]
                  * side_r[SIDE_DEPTH-1].mat_spc[LANE_W*i +: LANE_W];
        ta_r[i]  <= SUM_W'(amb_r[i]) << 14;
        td_r[i]  <= SUM_W'(dif_r[i]) * SUM_W'(c_fd_r);
        ts_r[i]  <= SUM_W'(spc_r[i]) * SUM_W'(c_fs_r);
        rgb_r[i] <= (q_c[i] > (SUM_W-32)'(16'hFFFF)) ? '1 : q_c[i][OUT_W-1:0];
      end
      c_fd_r <= fd_r[FD_DEPTH-1];
      c_fs_r <= fs_pow;
    end
  end

  // Round half up to Q2.14.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = ta_r[i] + td_r[i] + ts_r[i] + SUM_W'(64'h8000_0000);
      q_c[i]   = sum_c[i][SUM_W-1:32];
    end
  end

  assign out_ch.valid     = vld_r[LAT-1];
  assign out_ch.red_out   = rgb_r[0];
  assign out_ch.green_out = rgb_r[1];
  assign out_ch.blue_out  = rgb_r[2];

`ifndef NO_ASSERTIONS
  // A stalled pipeline must not drop or create transactions.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("valid bits moved while the pipeline was stalled");

  // The diffuse factor never exceeds one.
  a_fd_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NORM_END+2] |-> (fd_r[0] <= QUO_W'(Q14_ONE)))
    else $error("diffuse factor above one");

  // The specular power never exceeds one.
  a_fs_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SIDE_DEPTH-1] |-> (fs_pow <= QUO_W'(Q14_ONE)))
    else $error("specular factor above one");

  // No result is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

// ----- tb/sv/phong_lighting_tb.sv -----
// Self-checking testbench for the phong_lighting shading pipeline.
// Depends on plp_pkg and the plp_in_if, plp_out_if and plp_cfg_if interfaces
// (hw/rtl/plp_pkg.sv, hw/rtl/plp_if.sv) and on the phong_lighting RTL.
module phong_lighting_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plp_pkg::*;

  typedef longint vec3_t[3];

  typedef struct {
    logic [VEC_W-1:0]   pos;
    logic [VEC_W-1:0]   nrm;
    logic [VEC_W-1:0]   amb;
    logic [VEC_W-1:0]   dif;
    logic [VEC_W-1:0]   spc;
    logic [SHINE_W-1:0] shine;
  } shade_req_t;

  typedef struct {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } pixel_color_t;

  // First register index that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_IDX_W'(REG_CAMERA_POS + 1);
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst_n;

  plp_in_if  in_ch ();
  plp_out_if out_ch ();
  plp_cfg_if cfg_ch ();

  phong_lighting dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the light and camera registers.
  logic [VEC_W-1:0] light_pos_q, light_amb_q, light_dif_q, light_spc_q, camera_pos_q;

  pixel_color_t expected_colors[$];
  int  error_count;
  int  items_sent;
  int  colors_checked;
  int  ready_hold_cycles;
  bit  no_idle;

  // Clock.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------
  // Shading predictor.
  // ---------------------------------------------------------------------
  function automatic longint lane_signed(logic [VEC_W-1:0] w, int i);
    return longint'($signed(w[LANE_W*i +: LANE_W]));
  endfunction

  function automatic longint unsigned lane_unsigned(logic [VEC_W-1:0] w, int i);
    return longint'(w[LANE_W*i +: LANE_W]);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Unit vector in signed Q1.14; a zero vector stays zero.
  function automatic vec3_t normalize(vec3_t d);
    vec3_t u;
    longint unsigned sumsq, len, mag, q;
    sumsq = 0;
    foreach (d[i]) begin
      mag = (d[i] < 0) ? -d[i] : d[i];
      sumsq += mag * mag;
    end
    if (sumsq == 0) begin
      u = '{0, 0, 0};
      return u;
    end
    len = int_sqrt(sumsq << 16);
    foreach (d[i]) begin
      mag = (d[i] < 0) ? -d[i] : d[i];
      q = (mag << 22) / len;
      if (q > Q14_ONE) q = Q14_ONE;
      u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
    end
    return u;
  endfunction

  function automatic longint unsigned mul_q14(longint unsigned a, longint unsigned b);
    return (a * b + 8192) >> 14;
  endfunction

  // Square-and-multiply power; exponent zero gives one.
  function automatic longint unsigned pow_q14(longint unsigned base, logic [SHINE_W-1:0] e);
    longint unsigned r;
    r = Q14_ONE;
    for (int k = 0; k < SHINE_W; k++) begin
      if (e[k]) r = mul_q14(r, base);
      base = mul_q14(base, base);
    end
    return r;
  endfunction

  function automatic pixel_color_t shade_point(shade_req_t req);
    vec3_t dl, dn, dv, l, n, v;
    longint dnl, dvr, refl;
    longint unsigned fd, fs, amb, dif, spc, sum, q;
    logic [OUT_W-1:0] chan[3];
    pixel_color_t c;
    dnl = 0;
    dvr = 0;
    for (int i = 0; i < 3; i++) begin
      dl[i] = lane_signed(light_pos_q, i) - lane_signed(req.pos, i);
      dv[i] = lane_signed(camera_pos_q, i) - lane_signed(req.pos, i);
      dn[i] = lane_signed(req.nrm, i);
    end
    l = normalize(dl);
    n = normalize(dn);
    v = normalize(dv);
    for (int i = 0; i < 3; i++) dnl += n[i] * l[i];
    for (int i = 0; i < 3; i++) begin
      refl = 2 * dnl * n[i] - l[i] * (64'sd1 <<< 28);
      dvr += v[i] * refl;
    end
    if (dnl <= 0) fd = 0;
    else begin
      fd = longint'(dnl) >> 14;
      if (fd > Q14_ONE) fd = Q14_ONE;
    end
    if (dvr <= 0) fs = 0;
    else begin
      fs = longint'(dvr) >> 42;
      if (fs > Q14_ONE) fs = Q14_ONE;
    end
    fs = pow_q14(fs, req.shine);
    for (int i = 0; i < 3; i++) begin
      amb = lane_unsigned(light_amb_q, i) * lane_unsigned(req.amb, i);
      dif = lane_unsigned(light_dif_q, i) * lane_unsigned(req.dif, i);
      spc = lane_unsigned(light_spc_q, i) * lane_unsigned(req.spc, i);
      sum = (amb << 14) + dif * fd + spc * fs;
      q = (sum + (64'd1 << 31)) >> 32;
      if (q > 16'hFFFF) q = 16'hFFFF;
      chan[i] = q[OUT_W-1:0];
    end
    c.red   = chan[0];
    c.green = chan[1];
    c.blue  = chan[2];
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------
  // Sends one shading transaction; called at a falling edge, returns at one.
  task automatic send_point(shade_req_t req);
    in_ch.point_position    = req.pos;
    in_ch.surface_normal    = req.nrm;
    in_ch.material_ambient  = req.amb;
    in_ch.material_diffuse  = req.dif;
    in_ch.material_specular = req.spc;
    in_ch.shininess         = req.shine;
    in_ch.valid             = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_colors.push_back(shade_point(req));
    items_sent++;
    @(negedge clk);
  endtask

  // Sends a transaction, then sometimes leaves a gap on the input.
  task automatic send_with_gaps(shade_req_t req);
    send_point(req);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] value);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_LIGHT_POS:  light_pos_q  = value;
      REG_LIGHT_AMB:  light_amb_q  = value;
      REG_LIGHT_DIF:  light_dif_q  = value;
      REG_LIGHT_SPC:  light_spc_q  = value;
      REG_CAMERA_POS: camera_pos_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_all_colors();
    in_ch.valid = 1'b0;
    while (expected_colors.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Random values.
  // ---------------------------------------------------------------------
  function automatic logic [VEC_W-1:0] rand_word();
    return VEC_W'({$urandom(), $urandom()});
  endfunction

  // Packed vector with lanes in a modest range around the origin.
  function automatic logic [VEC_W-1:0] rand_near_vec(int span);
    logic [VEC_W-1:0] w;
    for (int i = 0; i < 3; i++)
      w[LANE_W*i +: LANE_W] = LANE_W'($signed($urandom_range(0, 2 * span)) - span);
    return w;
  endfunction

  function automatic shade_req_t rand_point();
    shade_req_t req;
    if ($urandom_range(0, 4) == 0) begin
      req.pos = rand_word();
      req.nrm = rand_word();
    end else begin
      req.pos = rand_near_vec(2048);
      req.nrm = rand_near_vec(512);
    end
    req.amb = rand_word();
    req.dif = rand_word();
    req.spc = rand_word();
    case ($urandom_range(0, 3))
      0:       req.shine = SHINE_W'($urandom_range(0, 3));
      1:       req.shine = SHINE_W'($urandom_range(4, 64));
      default: req.shine = SHINE_W'($urandom());
    endcase
    return req;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stalls plus a long hold on request.
  // ---------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (ready_hold_cycles > 0) begin
        ready_hold_cycles--;
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compares each accepted color against the oldest prediction.
  always @(posedge clk) begin
    pixel_color_t exp_c;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_colors.size() == 0) begin
        $error("unexpected color transaction r=%h g=%h b=%h",
               out_ch.red_out, out_ch.green_out, out_ch.blue_out);
        error_count++;
      end else begin
        exp_c = expected_colors.pop_front();
        colors_checked++;
        if (out_ch.red_out !== exp_c.red) begin
          $error("red_out: expected %h, got %h", exp_c.red, out_ch.red_out);
          error_count++;
        end
        if (out_ch.green_out !== exp_c.green) begin
          $error("green_out: expected %h, got %h", exp_c.green, out_ch.green_out);
          error_count++;
        end
        if (out_ch.blue_out !== exp_c.blue) begin
          $error("blue_out: expected %h, got %h", exp_c.blue, out_ch.blue_out);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------
  // With every register at reset the light is black, so colors are zero.
  task automatic test_reset_state();
    shade_req_t req;
    repeat (3) begin
      req = rand_point();
      send_with_gaps(req);
    end
    wait_all_colors();
  endtask

  // Corner cases of the geometry, the exponent and full-scale colors.
  task automatic test_directed();
    shade_req_t req;
    write_reg(REG_LIGHT_POS,  {16'h0000, 16'h0A00, 16'h0000});
    write_reg(REG_CAMERA_POS, {16'h0A00, 16'h0500, 16'h0000});
    write_reg(REG_LIGHT_AMB,  {3{16'h2000}});
    write_reg(REG_LIGHT_DIF,  {3{16'hFFFF}});
    write_reg(REG_LIGHT_SPC,  {3{16'hFFFF}});
    // Index beyond the last register must leave the state alone.
    write_reg(CFG_IDX_UNUSED, {3{16'h7FFF}});
    write_reg(CFG_IDX_UNUSED + 3'd2, '1);

    req = '{pos: '0, nrm: {16'h0000, 16'h0100, 16'h0000},
            amb: {3{16'hFFFF}}, dif: {3{16'hFFFF}}, spc: {3{16'hFFFF}}, shine: 8'd0};
    send_point(req);
    // Zero-length normal.
    req.nrm = '0;
    send_point(req);
    // Point at the light: zero-length light vector.
    req.nrm = {16'h0000, 16'h0100, 16'h0000};
    req.pos = {16'h0000, 16'h0A00, 16'h0000};
    send_point(req);
    // Point at the camera: zero-length view vector.
    req.pos = {16'h0A00, 16'h0500, 16'h0000};
    send_point(req);
    // Shininess extremes with a live base.
    req.pos = '0;
    req.shine = 8'd1;
    send_point(req);
    req.shine = 8'd255;
    send_point(req);
    req.shine = 8'd128;
    send_point(req);
    // Normal facing away from the light.
    req.nrm = {16'h0000, 16'hFF00, 16'h0000};
    req.shine = 8'd0;
    send_point(req);
    // Extreme lanes of position and normal.
    req = '{pos: {3{16'h7FFF}}, nrm: {3{16'h8000}}, amb: '1, dif: '1, spc: '1, shine: 8'd2};
    send_point(req);
    req.pos = {3{16'h8000}};
    req.nrm = {3{16'h7FFF}};
    send_point(req);
    req.pos = {16'h8000, 16'h7FFF, 16'h8000};
    req.nrm = {16'h0001, 16'hFFFF, 16'h0001};
    send_point(req);
    // Black materials.
    req = '{pos: '0, nrm: {16'h0000, 16'h0100, 16'h0000},
            amb: '0, dif: '0, spc: '0, shine: 8'd255};
    send_point(req);
    // Tiny normal components.
    req.nrm = {16'h0000, 16'h0001, 16'h0000};
    req.amb = {16'h0001, 16'h8000, 16'hFFFF};
    send_point(req);
    wait_all_colors();

    // Full-scale light and material colors give the largest outputs.
    write_reg(REG_LIGHT_AMB, '1);
    req = '{pos: '0, nrm: {16'h0000, 16'h0100, 16'h0000},
            amb: '1, dif: '1, spc: '1, shine: 8'd0};
    send_point(req);
    req.shine = 8'd7;
    send_point(req);
    wait_all_colors();
  endtask

  // Random points under a series of register settings, extremes included.
  task automatic test_random_phases(int phases, int per_phase);
    shade_req_t req;
    for (int p = 0; p < phases; p++) begin
      case (p % 4)
        0: begin
          write_reg(REG_LIGHT_POS,  rand_near_vec(4096));
          write_reg(REG_CAMERA_POS, rand_near_vec(4096));
          write_reg(REG_LIGHT_AMB,  rand_word());
          write_reg(REG_LIGHT_DIF,  rand_word());
          write_reg(REG_LIGHT_SPC,  rand_word());
        end
        1: begin
          write_reg(REG_LIGHT_POS,  {3{16'h7FFF}});
          write_reg(REG_CAMERA_POS, {3{16'h8000}});
          write_reg(REG_LIGHT_AMB,  '0);
          write_reg(REG_LIGHT_DIF,  '1);
          write_reg(REG_LIGHT_SPC,  '1);
        end
        2: begin
          write_reg(REG_LIGHT_POS,  rand_word());
          write_reg(REG_CAMERA_POS, rand_word());
          write_reg(REG_LIGHT_AMB,  '1);
          write_reg(REG_LIGHT_DIF,  '0);
          write_reg(REG_LIGHT_SPC,  rand_word());
        end
        default: begin
          write_reg(REG_LIGHT_POS,  {3{16'h8000}});
          write_reg(REG_CAMERA_POS, {3{16'h7FFF}});
          write_reg(REG_LIGHT_AMB,  rand_word());
          write_reg(REG_LIGHT_DIF,  rand_word());
          write_reg(REG_LIGHT_SPC,  '0);
          write_reg(CFG_IDX_UNUSED + 3'($urandom_range(0, 2)), rand_word());
        end
      endcase
      repeat (per_phase) begin
        req = rand_point();
        send_with_gaps(req);
      end
      wait_all_colors();
    end
  endtask

  // Result side holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure();
    shade_req_t req;
    ready_hold_cycles = 150;
    repeat (100) begin
      req = rand_point();
      send_point(req);
    end
    wait_all_colors();
  endtask

  // Back-to-back stream with no idling on either side.
  task automatic test_full_rate(int count);
    shade_req_t req;
    no_idle = 1'b1;
    write_reg(REG_LIGHT_POS,  rand_near_vec(2048));
    write_reg(REG_CAMERA_POS, rand_near_vec(2048));
    repeat (count) begin
      req = rand_point();
      send_point(req);
    end
    wait_all_colors();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.point_position = '0;
    in_ch.surface_normal = '0;
    in_ch.material_ambient = '0;
    in_ch.material_diffuse = '0;
    in_ch.material_specular = '0;
    in_ch.shininess = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LIGHT_POS;
    cfg_ch.data = '0;
    light_pos_q = '0;
    light_amb_q = '0;
    light_dif_q = '0;
    light_spc_q = '0;
    camera_pos_q = '0;
    error_count = 0;
    items_sent = 0;
    colors_checked = 0;
    ready_hold_cycles = 0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_directed();
    test_random_phases(5, 210);
    test_backpressure();
    test_full_rate(120);

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Shaded %0d points and checked %0d colors across directed corners,",
             items_sent, colors_checked);
    $display("random register settings, a long output stall and a full-rate stream.");
    if (error_count == 0 && expected_colors.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (expected_colors.size() != 0)
        $error("%0d colors never arrived", expected_colors.size());
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
